### design/cce_pkg.sv
// ----------------------------------------------------------------------------
// cce_pkg
// Shared types, register indexes and helper functions for the CRC engine.
// ----------------------------------------------------------------------------
package cce_pkg;

	localparam int CRC_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 3;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_WIDTH_CODE = 3'd0;
	localparam logic [INDEX_W-1:0] REG_POLYNOMIAL = 3'd1;
	localparam logic [INDEX_W-1:0] REG_REFLECTED  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_INVERT     = 3'd3;
	localparam logic [INDEX_W-1:0] REG_REVERSE    = 3'd4;

	// width codes
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_24 = 2'd2;
	localparam logic [1:0] WIDTH_32 = 2'd3;

	localparam logic [CRC_W-1:0] RESET_POLY = 32'hEDB8_8320;

	typedef struct packed {
		logic [1:0]       width_code;
		logic [CRC_W-1:0] poly;
		logic             reflected;
		logic             invert;
		logic             reverse;
	} crc_cfg_t;

	// ones in the low bits covered by the crc width
	function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] code);
		logic [CRC_W-1:0] m;
		case (code)
			WIDTH_8:  m = 32'h0000_00FF;
			WIDTH_16: m = 32'h0000_FFFF;
			WIDTH_24: m = 32'h00FF_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	// distance from the crc msb to bit 31
	function automatic logic [4:0] top_gap(input logic [1:0] code);
		logic [4:0] g;
		case (code)
			WIDTH_8:  g = 5'd24;
			WIDTH_16: g = 5'd16;
			WIDTH_24: g = 5'd8;
			default:  g = 5'd0;
		endcase
		return g;
	endfunction

	function automatic logic [CRC_W-1:0] bit_reverse(input logic [CRC_W-1:0] x);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = x[CRC_W-1-i];
		end
		return r;
	endfunction

endpackage

### design/cce_edge.sv
// ----------------------------------------------------------------------------
// cce_edge
// Entry/exit transform: optional invert, optional reverse within width, mask.
// ----------------------------------------------------------------------------
module cce_edge import cce_pkg::*; (
	input  crc_cfg_t         cfg,
	input  logic [CRC_W-1:0] crc_in,
	output logic [CRC_W-1:0] crc_out
);

	logic [CRC_W-1:0] mask;
	logic [CRC_W-1:0] inv;
	logic [CRC_W-1:0] rev;

	always_comb begin
		mask = width_mask(cfg.width_code);
		inv  = (cfg.invert ? ~crc_in : crc_in) & mask;
		// reversing the full word puts the field at the top, shift it back down
		rev  = bit_reverse(inv) >> top_gap(cfg.width_code);
		crc_out = (cfg.reverse ? rev : inv) & mask;
	end

endmodule

### design/cce_fold.sv
// ----------------------------------------------------------------------------
// cce_fold
// Folds one message byte into the crc with eight shift-and-reduce steps.
// ----------------------------------------------------------------------------
module cce_fold import cce_pkg::*; (
	input  crc_cfg_t          cfg,
	input  logic [CRC_W-1:0]  crc_in,
	input  logic [BYTE_W-1:0] data,
	output logic [CRC_W-1:0]  crc_out
);

	logic [CRC_W-1:0] mask;
	logic [CRC_W-1:0] poly;
	logic [4:0]       gap;
	logic [CRC_W-1:0] lsb_crc;
	logic [CRC_W-1:0] msb_crc;
	logic [CRC_W-1:0] msb_poly;

	always_comb begin
		mask = width_mask(cfg.width_code);
		poly = cfg.poly & mask;
		gap  = top_gap(cfg.width_code);

		// lsb first
		lsb_crc = (crc_in & mask) ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			lsb_crc = lsb_crc[0] ? ((lsb_crc >> 1) ^ poly) : (lsb_crc >> 1);
		end

		// msb first, done with the crc aligned to bit 31 so the top bit is fixed
		msb_poly = poly << gap;
		msb_crc  = ((crc_in & mask) << gap) ^ {data, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			msb_crc = msb_crc[CRC_W-1] ? ((msb_crc << 1) ^ msb_poly) : (msb_crc << 1);
		end

		crc_out = cfg.reflected ? lsb_crc : ((msb_crc >> gap) & mask);
	end

endmodule

### design/configurable_crc_engine_core.sv
// ----------------------------------------------------------------------------
// configurable_crc_engine_core
// Items are held in the input registers, final crcs in the result register.
// Throughput: one byte per cycle unless a result waits on a full output; the
// entry transform, eight-step byte fold and exit transform sit between them.
// Reset: config registers take their defaults, running crc clears to zero.
// ----------------------------------------------------------------------------
module configurable_crc_engine_core import cce_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [INDEX_W-1:0]  cfg_index,
	input  logic [CRC_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [BYTE_W-1:0]   data_byte,
	input  logic                has_byte,
	input  logic                first_item,
	input  logic [CRC_W-1:0]    seed_value,
	input  logic                last_item,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CRC_W-1:0]    crc_value
);

	crc_cfg_t          cfg_q;
	logic [CRC_W-1:0]  running_crc_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              has_s1;
	logic              first_s1;
	logic [CRC_W-1:0]  seed_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [CRC_W-1:0]  crc_value_q;

	logic [CRC_W-1:0]  entry_crc;
	logic [CRC_W-1:0]  base_crc;
	logic [CRC_W-1:0]  fold_crc;
	logic [CRC_W-1:0]  next_crc;
	logic [CRC_W-1:0]  exit_crc;
	logic              advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_code <= WIDTH_32;
			cfg_q.poly       <= RESET_POLY;
			cfg_q.reflected  <= 1'b1;
			cfg_q.invert     <= 1'b1;
			cfg_q.reverse    <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_WIDTH_CODE: cfg_q.width_code <= cfg_data[1:0];
				REG_POLYNOMIAL: cfg_q.poly       <= cfg_data;
				REG_REFLECTED:  cfg_q.reflected  <= cfg_data[0];
				REG_INVERT:     cfg_q.invert     <= cfg_data[0];
				REG_REVERSE:    cfg_q.reverse    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// a staged transaction moves on unless it has a result and the output is full
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			has_s1   <= has_byte;
			first_s1 <= first_item;
			seed_s1  <= seed_value;
			last_s1  <= last_item;
		end
	end

	cce_edge u_entry (
		.cfg     (cfg_q),
		.crc_in  (seed_s1),
		.crc_out (entry_crc)
	);

	assign base_crc = first_s1 ? entry_crc : running_crc_q;

	cce_fold u_fold (
		.cfg     (cfg_q),
		.crc_in  (base_crc),
		.data    (data_s1),
		.crc_out (fold_crc)
	);

	assign next_crc = has_s1 ? fold_crc : base_crc;

	cce_edge u_exit (
		.cfg     (cfg_q),
		.crc_in  (next_crc),
		.crc_out (exit_crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
		end else if (advance) begin
			running_crc_q <= next_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			crc_value_q <= exit_crc;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

endmodule

### tb/configurable_crc_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// configurable_crc_engine_core_tb
// Runs byte streams through the CRC engine under a series of widths,
// polynomials and transform flags. A scoreboard folds each accepted byte into
// its own running CRC and checks every result against it. Both sides idle at
// random, and the result side once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module configurable_crc_engine_core_tb;
	import cce_pkg::*;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              has;
		logic              first;
		logic [CRC_W-1:0]  seed;
		logic              last;
	} crc_item_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_write  = 1'b0;
	logic [INDEX_W-1:0] cfg_index  = '0;
	logic [CRC_W-1:0]   cfg_data   = '0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [BYTE_W-1:0]  data_byte  = '0;
	logic               has_byte   = 1'b0;
	logic               first_item = 1'b0;
	logic [CRC_W-1:0]   seed_value = '0;
	logic               last_item  = 1'b0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [CRC_W-1:0]   crc_value;

	configurable_crc_engine_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.first_item (first_item),
		.seed_value (seed_value),
		.last_item  (last_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.crc_value  (crc_value)
	);

	// scoreboard copy of the engine state
	logic [1:0]       m_width = WIDTH_32;
	logic [CRC_W-1:0] m_poly  = RESET_POLY;
	logic             m_refl  = 1'b1;
	logic             m_inv   = 1'b1;
	logic             m_rev   = 1'b0;
	logic [CRC_W-1:0] crc_acc = '0;

	crc_item_t        byte_q[$];
	logic [CRC_W-1:0] crc_expect_q[$];
	crc_item_t        bus_item;
	bit               in_taken  = 1'b0;
	bit               idle_on   = 1'b1;
	bit               hold_req  = 1'b0;
	int               n_pushed  = 0;
	int               n_accepted = 0;
	int               errors    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int lane_bits();
		return 8 * (int'(m_width) + 1);
	endfunction

	function automatic logic [CRC_W-1:0] lane_mask();
		return 32'hFFFF_FFFF >> (32 - lane_bits());
	endfunction

	function automatic logic [CRC_W-1:0] reverse_lane(input logic [CRC_W-1:0] x);
		logic [CRC_W-1:0] r;
		int n;
		n = lane_bits();
		r = '0;
		for (int i = 0; i < n; i++) begin
			r[n-1-i] = x[i];
		end
		return r;
	endfunction

	// applied both when loading a seed and when producing the result
	function automatic logic [CRC_W-1:0] edge_xform(input logic [CRC_W-1:0] x);
		if (m_inv) begin
			x = ~x;
		end
		x = x & lane_mask();
		if (m_rev) begin
			x = reverse_lane(x);
		end
		return x & lane_mask();
	endfunction

	function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] msk;
		logic [CRC_W-1:0] p;
		int n;
		n = lane_bits();
		msk = lane_mask();
		p = m_poly & msk;
		acc = acc & msk;
		if (m_refl) begin
			acc = acc ^ {24'h0, b};
			for (int k = 0; k < 8; k++) begin
				acc = acc[0] ? ((acc >> 1) ^ p) : (acc >> 1);
			end
		end else begin
			acc = acc ^ ({24'h0, b} << (n - 8));
			for (int k = 0; k < 8; k++) begin
				acc = acc[n-1] ? (((acc << 1) ^ p) & msk) : ((acc << 1) & msk);
			end
		end
		return acc & msk;
	endfunction

	task automatic fold_item(input crc_item_t it);
		if (it.first) begin
			crc_acc = edge_xform(it.seed);
		end
		if (it.has) begin
			crc_acc = fold_byte(crc_acc, it.data);
		end
		if (it.last) begin
			crc_expect_q.push_back(edge_xform(crc_acc & lane_mask()));
		end
	endtask

	// sender: new transaction only after the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			if (byte_q.size() > 0) begin
				bus_item = byte_q.pop_front();
				data_byte  <= bus_item.data;
				has_byte   <= bus_item.has;
				first_item <= bus_item.first;
				seed_value <= bus_item.seed;
				last_item  <= bus_item.last;
				in_valid   <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		int hold_cnt;
		int stall_cnt;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_cnt = $urandom_range(1, 16);
			end
		end
	end

	// monitor: predict on input transaction, check on result transaction
	always @(posedge clk) begin
		logic [CRC_W-1:0] want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				fold_item(bus_item);
				n_accepted++;
				in_taken = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (crc_expect_q.size() == 0) begin
					$display("%0t: unexpected crc result, expected none actual %h",
						$time, crc_value);
					errors++;
				end else begin
					want = crc_expect_q.pop_front();
					if (crc_value !== want) begin
						$display("%0t: crc_value mismatch, expected %h actual %h",
							$time, want, crc_value);
						errors++;
					end
				end
			end
		end
	end

	task automatic push_item(input logic [BYTE_W-1:0] data, input logic has,
			input logic first, input logic [CRC_W-1:0] seed, input logic last);
		crc_item_t it;
		it.data = data;
		it.has = has;
		it.first = first;
		it.seed = seed;
		it.last = last;
		byte_q.push_back(it);
		n_pushed++;
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CRC_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_WIDTH_CODE: m_width = val[1:0];
			REG_POLYNOMIAL: m_poly  = val;
			REG_REFLECTED:  m_refl  = val[0];
			REG_INVERT:     m_inv   = val[0];
			REG_REVERSE:    m_rev   = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input logic [1:0] wc, input logic [CRC_W-1:0] poly,
			input logic refl, input logic inv, input logic rev);
		write_reg(REG_WIDTH_CODE, {30'h0, wc});
		write_reg(REG_POLYNOMIAL, poly);
		write_reg(REG_REFLECTED, {31'h0, refl});
		write_reg(REG_INVERT, {31'h0, inv});
		write_reg(REG_REVERSE, {31'h0, rev});
	endtask

	// bytes without a result may still be in flight, so linger a little
	task automatic wait_idle();
		while (n_accepted != n_pushed || crc_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// mostly well-formed messages, some stray transactions in between
	task automatic queue_messages(input int n_items);
		int left;
		int len;
		left = n_items;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(BYTE_W'($urandom), 1'($urandom), 1'($urandom), $urandom,
					1'($urandom));
				left--;
			end else begin
				case ($urandom_range(0, 9))
					0: len = 0;
					1: len = $urandom_range(9, 40);
					default: len = $urandom_range(1, 8);
				endcase
				if (len == 0) begin
					push_item(BYTE_W'($urandom), 1'b0, 1'b1, $urandom, 1'b1);
					left--;
				end else begin
					for (int k = 0; k < len; k++) begin
						push_item(BYTE_W'($urandom), $urandom_range(0, 15) != 0, k == 0,
							$urandom, k == len - 1);
					end
					left -= len;
				end
			end
		end
	endtask

	localparam int N_PHASES = 14;

	initial begin
		logic [1:0]       ph_width[12] = '{WIDTH_32, WIDTH_32, WIDTH_16, WIDTH_16,
			WIDTH_16, WIDTH_16, WIDTH_32, WIDTH_32, WIDTH_8, WIDTH_24, WIDTH_8, WIDTH_24};
		logic [CRC_W-1:0] ph_poly[12] = '{32'h04c11db7, 32'hedb88320, 32'h00001021,
			32'h00008408, 32'h00008005, 32'h0000a001, 32'h1edc6f41, 32'h82f63b78,
			32'h00000007, 32'h55555555, 32'hffffffff, 32'h00000000};
		logic             ph_refl[12] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
			1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		logic [BYTE_W-1:0] check_str[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
			8'h36, 8'h37, 8'h38, 8'h39};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config; a byte on the cleared state, then the check string
		push_item(8'hA5, 1'b1, 1'b0, 32'h0, 1'b1);
		for (int k = 0; k < 9; k++) begin
			push_item(check_str[k], 1'b1, k == 0, 32'h0, k == 8);
		end
		// empty messages, extreme bytes and seeds
		push_item(8'h00, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1);
		push_item(8'hFF, 1'b0, 1'b1, 32'h0000_0000, 1'b1);
		push_item(8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
		push_item(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
		push_item(8'h5A, 1'b0, 1'b0, 32'h1234_5678, 1'b0);
		push_item(8'h00, 1'b0, 1'b0, 32'h0, 1'b1);
		// message that continues after a width change
		push_item(8'hC3, 1'b1, 1'b1, 32'hDEAD_BEEF, 1'b0);
		push_item(8'h3C, 1'b1, 1'b0, 32'h0, 1'b0);
		wait_idle();

		// narrow crc, polynomial wider than the width, reversal on
		set_config(WIDTH_8, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
		push_item(8'h81, 1'b1, 1'b0, 32'h0, 1'b1);
		push_item(8'h7E, 1'b1, 1'b1, 32'hFFFF_FF01, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0, 32'h0, 1'b1);
		push_item(8'h00, 1'b0, 1'b1, 32'h0000_00F0, 1'b1);
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 12) begin
				set_config(ph_width[ph], ph_poly[ph], ph_refl[ph], ph[0], ph[1]);
			end else begin
				set_config(2'($urandom_range(0, 3)), $urandom, 1'($urandom),
					1'($urandom), 1'($urandom));
			end
			if (ph == N_PHASES - 1) begin
				idle_on = 1'b0;
			end
			queue_messages(100);
			if (ph == 1) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (crc_expect_q.size() != 0) begin
			$display("%0t: %0d crc results never arrived, next expected %h",
				$time, crc_expect_q.size(), crc_expect_q[0]);
			errors++;
		end
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### configurable_crc_engine_core.f
design/cce_pkg.sv
design/cce_edge.sv
design/cce_fold.sv
design/configurable_crc_engine_core.sv
tb/configurable_crc_engine_core_tb.sv
